// ===== rtl/twvp_pkg.sv =====
// Shared widths, register codes, types and state encodings of the wheel PID core.
package twvp_pkg;

    localparam int NUM_WHEELS = 3;

    localparam int ENC_W  = 32;
    localparam int TGT_W  = 16;
    localparam int LIM_W  = 17;
    localparam int GAIN_W = 10;
    localparam int PER_W  = 16;
    localparam int INT_W  = 48;

    localparam int ERR_W  = ENC_W + 1;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int SUM_W  = ((INT_W > PROD_W) ? INT_W : PROD_W) + 1;
    localparam int DRV_W  = SUM_W + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = PER_W;

    // Input word: encoders, then targets, then limits.
    localparam int TGT_OFS  = NUM_WHEELS * ENC_W;
    localparam int LIM_OFS  = TGT_OFS + NUM_WHEELS * TGT_W;
    localparam int S_PAY_W  = LIM_OFS + NUM_WHEELS * LIM_W;
    localparam int S_DATA_W = ((S_PAY_W + 7) / 8) * 8;

    // Output word: drives, then speeds.
    localparam int SPD_OFS  = NUM_WHEELS * LIM_W;
    localparam int M_PAY_W  = SPD_OFS + NUM_WHEELS * ENC_W;
    localparam int M_DATA_W = ((M_PAY_W + 7) / 8) * 8;

    localparam logic [CFG_AW-1:0] REG_KP  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KD  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KI  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KO  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PER = 3'd4;

    localparam logic [GAIN_W-1:0] KP_RST  = 10'd5;
    localparam logic [GAIN_W-1:0] KD_RST  = 10'd15;
    localparam logic [GAIN_W-1:0] KI_RST  = 10'd0;
    localparam logic [GAIN_W-1:0] KO_RST  = 10'd50;
    localparam logic [PER_W-1:0]  PER_RST = 16'd1000;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] ko;
        logic [PER_W-1:0]  pwm_period;
    } twvp_cfg_t;

    typedef struct packed {
        logic start;
        logic moving;
        logic clear;
    } twvp_lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic speed_nz;
    } twvp_lane_stat_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_MUL,
        LN_SUM,
        LN_LOAD,
        LN_DIV,
        LN_FIN
    } lane_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_WAIT
    } core_state_t;

endpackage

// ===== rtl/twvp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module twvp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [twvp_pkg::SUM_W-1:0]  dividend,
    input  logic [twvp_pkg::GAIN_W-1:0] divisor,
    output logic [twvp_pkg::SUM_W-1:0]  quot,
    output logic                        done
);
    import twvp_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [GAIN_W-1:0] rem_reg, rem_next;
    logic [GAIN_W-1:0] dvs_reg, dvs_next;

    logic [GAIN_W:0]   trial;
    logic [GAIN_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quot_reg[SUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift dividend out the top, quotient bit in the bottom
            quot_next = {quot_reg[SUM_W-2:0], ge};
            rem_next  = ge ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg <= LAST_STEP))
        else $error("divider step count out of range");

endmodule

// ===== rtl/twvp_lane.sv =====
// One wheel's velocity PID lane: speed, error terms, division, clamp and anti-windup.
module twvp_lane (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  twvp_pkg::twvp_cfg_t                 cfg,
    input  twvp_pkg::twvp_lane_ctl_t            ctl,
    input  logic signed [twvp_pkg::ENC_W-1:0]   enc,
    input  logic signed [twvp_pkg::TGT_W-1:0]   tgt,
    input  logic signed [twvp_pkg::LIM_W-1:0]   lim,
    output logic signed [twvp_pkg::LIM_W-1:0]   drive,
    output logic signed [twvp_pkg::ENC_W-1:0]   speed,
    output twvp_pkg::twvp_lane_stat_t           stat
);
    import twvp_pkg::*;

    lane_state_t state_reg, state_next;

    // wheel state
    logic signed [ENC_W-1:0] prev_count_reg, prev_count_next;
    logic signed [ENC_W-1:0] prev_speed_reg, prev_speed_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;
    logic signed [LIM_W-1:0] last_drive_reg, last_drive_next;

    // per-tick working values
    logic signed [ERR_W-1:0]  err_reg, dspd_reg;
    logic [PER_W-1:0]         mx_reg;
    logic signed [PROD_W-1:0] p_reg, d_reg, i_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DRV_W-1:0]  drv_reg;

    logic signed [ENC_W-1:0]  spd_new;
    logic signed [ERR_W-1:0]  err_new, dspd_new;
    logic signed [LIM_W:0]    lim_ext;
    logic [LIM_W:0]           lim_mag;
    logic [PER_W-1:0]         mx_new;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [DRV_W-1:0]  q_ext, drv_new, mx_ext;
    logic signed [INT_W:0]    isum;
    logic signed [INT_W-1:0]  integ_sat;
    logic [LIM_W-1:0]         ld_mag;

    logic                     div_start, div_done;
    logic [GAIN_W-1:0]        div_dvs;
    logic [SUM_W-1:0]         div_quot;

    always_comb begin
        spd_new  = enc - prev_count_reg;
        err_new  = ERR_W'(tgt) - ERR_W'(spd_new);
        dspd_new = ERR_W'(spd_new) - ERR_W'(prev_speed_reg);
        lim_ext  = (LIM_W+1)'(lim);
        lim_mag  = (lim_ext < 0) ? (LIM_W+1)'(-lim_ext) : (LIM_W+1)'(lim_ext);
        mx_new   = (lim_mag > (LIM_W+1)'(cfg.pwm_period)) ? cfg.pwm_period
                                                          : lim_mag[PER_W-1:0];
        sum_new  = SUM_W'(p_reg) - SUM_W'(d_reg) + SUM_W'(integ_reg);
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_dvs  = (cfg.ko == '0) ? GAIN_W'(1) : cfg.ko;
        q_ext    = $signed({1'b0, div_quot});
        // truncating quotient takes the sign of the sum
        drv_new  = sum_reg[SUM_W-1] ? (DRV_W'(last_drive_reg) - q_ext)
                                    : (DRV_W'(last_drive_reg) + q_ext);
        mx_ext   = $signed({{(DRV_W-PER_W){1'b0}}, mx_reg});
        isum     = (INT_W+1)'(integ_reg) + (INT_W+1)'(i_reg);
        if (isum[INT_W] != isum[INT_W-1]) begin
            integ_sat = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                    : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            integ_sat = isum[INT_W-1:0];
        end
        ld_mag   = last_drive_reg[LIM_W-1] ? LIM_W'(-last_drive_reg)
                                           : LIM_W'(last_drive_reg);
    end

    twvp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (div_dvs),
        .quot     (div_quot),
        .done     (div_done)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE: begin
                if (ctl.start && ctl.moving) state_next = LN_MUL;
            end
            LN_MUL:  state_next = LN_SUM;
            LN_SUM:  state_next = LN_LOAD;
            LN_LOAD: state_next = LN_DIV;
            LN_DIV: begin
                if (div_done) state_next = LN_FIN;
            end
            LN_FIN:  state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        div_start     = (state_reg == LN_LOAD);
        stat.busy     = (state_reg != LN_IDLE);
        stat.speed_nz = (prev_speed_reg != '0);
    end

    // wheel state update
    always_comb begin
        prev_count_next = prev_count_reg;
        prev_speed_next = prev_speed_reg;
        integ_next      = integ_reg;
        last_drive_next = last_drive_reg;
        case (state_reg)
            LN_IDLE: begin
                if (ctl.start) begin
                    if (ctl.moving) begin
                        prev_count_next = enc;
                        prev_speed_next = spd_new;
                    end else if (ctl.clear) begin
                        prev_count_next = enc;
                        prev_speed_next = '0;
                        integ_next      = '0;
                        last_drive_next = '0;
                    end
                end
            end
            LN_FIN: begin
                if (drv_reg >= mx_ext) begin
                    last_drive_next = LIM_W'(mx_ext);
                end else if (drv_reg <= -mx_ext) begin
                    last_drive_next = LIM_W'(-mx_ext);
                end else begin
                    // integrate only while the drive is unclamped
                    last_drive_next = LIM_W'(drv_reg);
                    integ_next      = integ_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= LN_IDLE;
            prev_count_reg <= '0;
            prev_speed_reg <= '0;
            integ_reg      <= '0;
            last_drive_reg <= '0;
        end else begin
            state_reg      <= state_next;
            prev_count_reg <= prev_count_next;
            prev_speed_reg <= prev_speed_next;
            integ_reg      <= integ_next;
            last_drive_reg <= last_drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LN_IDLE: begin
                err_reg  <= err_new;
                dspd_reg <= dspd_new;
                mx_reg   <= mx_new;
            end
            LN_MUL: begin
                p_reg <= PROD_W'($signed({1'b0, cfg.kp})) * PROD_W'(err_reg);
                d_reg <= PROD_W'($signed({1'b0, cfg.kd})) * PROD_W'(dspd_reg);
                i_reg <= PROD_W'($signed({1'b0, cfg.ki})) * PROD_W'(err_reg);
            end
            LN_SUM: sum_reg <= sum_new;
            LN_DIV: begin
                if (div_done) drv_reg <= drv_new;
            end
            default: ;
        endcase
    end

    assign drive = last_drive_reg;
    assign speed = prev_speed_reg;

    a_drive_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == LN_FIN) |=> (ld_mag <= LIM_W'(mx_reg)))
        else $error("lane drive exceeds its limit after clamp");

endmodule

// ===== rtl/three_wheel_velocity_pid_core.sv =====
// Top level of the three-wheel velocity PID core: config, lanes, merge and output register.
//
// One input word per control tick on s_*: encoder counts, speed targets and drive
// limits for every wheel in s_tdata, the moving flag in s_tuser. One output word
// per tick on m_*: clamped drives and measured speeds in m_tdata, the driven flag
// in m_tuser. Gains, output divisor and PWM period are to be written through cfg_*
// only while the core is idle; the core itself does not enforce this. They take
// effect on the next tick. A moving tick runs all wheels side by side; each lane
// steps through multiply, sum, load, its 49-step shift-subtract divider and
// finish before m_tvalid. An idle tick skips the lanes and loads its word into
// the output register. s_tready rises again the cycle after the word is loaded,
// so no new tick is taken until the previous tick's word is loaded.
// The output register holds a finished word while m_tready is low, and a new
// tick is accepted meanwhile; its result waits in the lanes until the register
// frees up.
// Reset clears all wheel state to zero and loads the default configuration.
module three_wheel_velocity_pid_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [twvp_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [twvp_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // enc_a, enc_b, enc_c, target_a, target_b, target_c, limit_a, limit_b, limit_c
    input  logic [twvp_pkg::S_DATA_W-1:0] s_tdata,
    // moving
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_a, drive_b, drive_c, speed_a, speed_b, speed_c
    output logic [twvp_pkg::M_DATA_W-1:0] m_tdata,
    // driven
    output logic                          m_tuser
);
    import twvp_pkg::*;

    core_state_t state_reg, state_next;

    logic [GAIN_W-1:0] kp_reg, kd_reg, ki_reg, ko_reg;
    logic [PER_W-1:0]  per_reg;
    twvp_cfg_t         cfg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_word;
    logic                  m_tuser_reg;
    logic                  moving_reg;

    logic                  s_accept;
    logic                  load_out;
    logic                  any_speed;
    logic                  any_busy;
    twvp_lane_ctl_t        lane_ctl;

    logic signed [LIM_W-1:0] lane_drive [NUM_WHEELS];
    logic signed [ENC_W-1:0] lane_speed [NUM_WHEELS];
    twvp_lane_stat_t         lane_stat  [NUM_WHEELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg  <= KP_RST;
            kd_reg  <= KD_RST;
            ki_reg  <= KI_RST;
            ko_reg  <= KO_RST;
            per_reg <= PER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KP:  kp_reg  <= cfg_data[GAIN_W-1:0];
                REG_KD:  kd_reg  <= cfg_data[GAIN_W-1:0];
                REG_KI:  ki_reg  <= cfg_data[GAIN_W-1:0];
                REG_KO:  ko_reg  <= cfg_data[GAIN_W-1:0];
                REG_PER: per_reg <= cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.kp         = kp_reg;
        cfg.kd         = kd_reg;
        cfg.ki         = ki_reg;
        cfg.ko         = ko_reg;
        cfg.pwm_period = per_reg;
    end

    // merge: lane status reduction and output word
    always_comb begin
        any_speed = 1'b0;
        any_busy  = 1'b0;
        m_word    = '0;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            any_speed = any_speed | lane_stat[w].speed_nz;
            any_busy  = any_busy  | lane_stat[w].busy;
            m_word[w*LIM_W +: LIM_W]           = lane_drive[w];
            m_word[SPD_OFS + w*ENC_W +: ENC_W] = lane_speed[w];
        end
    end

    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        lane_ctl.start  = s_accept;
        lane_ctl.moving = s_tuser;
        lane_ctl.clear  = any_speed;
    end

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        twvp_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg),
            .ctl     (lane_ctl),
            .enc     ($signed(s_tdata[g*ENC_W +: ENC_W])),
            .tgt     ($signed(s_tdata[TGT_OFS + g*TGT_W +: TGT_W])),
            .lim     ($signed(s_tdata[LIM_OFS + g*LIM_W +: LIM_W])),
            .drive   (lane_drive[g]),
            .speed   (lane_speed[g]),
            .stat    (lane_stat[g])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_BUSY;
            end
            ST_BUSY: begin
                if (!any_busy) state_next = load_out ? ST_IDLE : ST_WAIT;
            end
            ST_WAIT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        load_out = ((state_reg == ST_BUSY) && !any_busy && (!m_tvalid_reg || m_tready))
                || ((state_reg == ST_WAIT) && m_tready);
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) moving_reg <= s_tuser;
        if (load_out) begin
            m_tdata_reg <= m_word;
            m_tuser_reg <= moving_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_ready_lanes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !any_busy)
        else $error("input ready while a lane is still working");

    a_valid_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg != ST_IDLE))
        else $error("output word appeared without a tick in progress");

    a_wait_holds_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> m_tvalid_reg)
        else $error("waiting for output space with an empty output register");

endmodule
